### design/hbbc_pkg.sv
`timescale 1ns / 1ps
package hbbc_pkg;

   localparam int REFS_MAX = 63;

   typedef enum logic [1:0] {
      KIND_GET     = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_PIN     = 2'd2,
      KIND_UNPIN   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_FREE   = 2'd1,
      STATUS_UNDERFLOW = 2'd2,
      STATUS_OVERFLOW  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] device_id;
      logic [31:0] block_number;
      logic [4:0]  buffer_index;
   } req_type;

   typedef struct packed {
      logic [4:0] slot;
      logic       hit;
      logic       needs_read;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD,
      ST_HRD,
      ST_HCHK,
      ST_HWR,
      ST_VRD,
      ST_VCHK,
      ST_VBKT,
      ST_VWR,
      ST_RRD,
      ST_RCHK,
      ST_DONE
   } state_type;

endpackage

### design/hbbc_entry_ram.sv
`timescale 1ns / 1ps
// entry memory: one write port, one registered read port
module hbbc_entry_ram #(
   parameter int AW = 5,
   parameter int DW = 64
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   logic [DW-1:0] mem [2**AW];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### design/hashed_block_buffer_cache_core.sv
`timescale 1ns / 1ps
// channel | ports                       | transfer
// request | start, busy, req_item       | start && !busy
// result  | rsp_valid, rsp_item         | rsp_valid, one cycle
// release/pin/unpin: read the slot, then update its count; a release that
// drops the count to zero adds a recency pass over the entry memory.
// get: home bucket by a byte fold plus table, then one hit pass over
// the entry memory. a miss adds up to one pass per other bucket and, if a
// free victim is found, a recency pass; each pass reads the entries one by
// one through the single memory read port. after reset an init sweep writes
// entry defaults, busy high. the receiver cannot stall.
module hashed_block_buffer_cache_core #(
   parameter int NUM_BUFFERS = 32,
   parameter int NUM_BUCKETS = 13
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  hbbc_pkg::req_type req_item,
   output logic              rsp_valid,
   output hbbc_pkg::rsp_type rsp_item
);
   localparam int AW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam int BW = $clog2(NUM_BUCKETS);
   localparam int CW = AW + 1;
   // entry word: device, block, refs, valid, bucket, rank
   localparam int DW = 16 + 32 + 6 + 1 + BW + AW;
   // weights of the upper bytes of the block number, modulo the bucket count
   localparam int MOD_C1 = 256 % NUM_BUCKETS;
   localparam int MOD_C2 = (MOD_C1 * 256) % NUM_BUCKETS;
   localparam int MOD_C3 = (MOD_C2 * 256) % NUM_BUCKETS;

   // byte value modulo bucket count
   function automatic logic [256*BW-1:0] mod_table();
      logic [256*BW-1:0] t;
      t = '0;
      for (int i = 0; i < 256; i++) begin
         t[i*BW +: BW] = BW'(i % NUM_BUCKETS);
      end
      return t;
   endfunction

   localparam logic [256*BW-1:0] MOD_TBL = mod_table();

   typedef struct packed {
      logic [15:0]   dev;
      logic [31:0]   blk;
      logic [5:0]    refs;
      logic          valid;
      logic [BW-1:0] bucket;
      logic [AW-1:0] rank;
   } entry_type;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_data;

   hbbc_entry_ram #(.AW(AW), .DW(DW)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   hbbc_pkg::state_type state_ff, state_in;
   hbbc_pkg::req_type req_ff, req_in;
   logic init_ff, init_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [BW-1:0] sc_ff, sc_in;
   logic [BW-1:0] home_ff, home_in;
   logic [BW-1:0] bkt_ff, bkt_in;
   logic found_ff, found_in;
   logic [AW-1:0] best_ff, best_in;
   logic [AW-1:0] brank_ff, brank_in;
   entry_type bent_ff, bent_in;
   logic [AW-1:0] old_ff, old_in;
   logic [AW-1:0] raddr_ff, raddr_in;
   logic [31:0] rem_ff, rem_in;
   logic [5:0] mstep_ff, mstep_in;
   logic rv_ff, rv_in;
   hbbc_pkg::rsp_type rsp_ff, rsp_in;

   logic [BW-1:0] init_bucket;
   logic [CW-1:0] cnt_nx;
   logic [AW-1:0] scan_idx;

   assign busy      = init_ff || (state_ff != hbbc_pkg::ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_item  = rsp_ff;
   assign rd_addr   = raddr_in;
   assign cnt_nx    = cnt_ff + CW'(1);
   assign scan_idx  = cnt_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hbbc_pkg::ST_IDLE;
         init_ff  <= 1'b1;
         cnt_ff   <= '0;
         sc_ff    <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         cnt_ff   <= cnt_in;
         sc_ff    <= sc_in;
         rv_ff    <= rv_in;
      end
      req_ff   <= req_in;
      home_ff  <= home_in;
      bkt_ff   <= bkt_in;
      found_ff <= found_in;
      best_ff  <= best_in;
      brank_ff <= brank_in;
      bent_ff  <= bent_in;
      old_ff   <= old_in;
      raddr_ff <= raddr_in;
      rem_ff   <= rem_in;
      mstep_ff <= mstep_in;
      rsp_ff   <= rsp_in;
   end

   // init bucket tracks slot modulo bucket count
   assign init_bucket = sc_ff;

   always_comb begin
      state_in = state_ff;
      init_in  = init_ff;
      cnt_in   = cnt_ff;
      sc_in    = sc_ff;
      req_in   = req_ff;
      home_in  = home_ff;
      bkt_in   = bkt_ff;
      found_in = found_ff;
      best_in  = best_ff;
      brank_in = brank_ff;
      bent_in  = bent_ff;
      old_in   = old_ff;
      raddr_in = raddr_ff;
      rem_in   = rem_ff;
      mstep_in = mstep_ff;
      rv_in    = 1'b0;
      rsp_in   = rsp_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = rd_data;

      if (init_ff) begin
         // reset sweep of entry defaults
         wr_en          = 1'b1;
         wr_addr        = cnt_ff[AW-1:0];
         wr_data        = '0;
         wr_data.bucket = init_bucket;
         wr_data.rank   = cnt_ff[AW-1:0];
         cnt_in         = cnt_nx;
         sc_in          = (32'(sc_ff) == NUM_BUCKETS - 1) ? '0 : sc_ff + BW'(1);
         if (32'(cnt_nx) == NUM_BUFFERS) begin
            init_in = 1'b0;
            cnt_in  = '0;
         end
      end else begin
         case (state_ff)
            hbbc_pkg::ST_IDLE: begin
               if (start) begin
                  req_in = req_item;
                  if (req_item.kind == hbbc_pkg::KIND_GET) begin
                     rem_in   = req_item.block_number;
                     mstep_in = '0;
                     state_in = hbbc_pkg::ST_MOD;
                  end else if (32'(req_item.buffer_index) >= NUM_BUFFERS) begin
                     rsp_in   = '{req_item.buffer_index, 1'b0, 1'b0,
                                  hbbc_pkg::STATUS_OK};
                     state_in = hbbc_pkg::ST_DONE;
                  end else begin
                     raddr_in = AW'(req_item.buffer_index);
                     state_in = hbbc_pkg::ST_VRD;
                  end
               end
            end
            hbbc_pkg::ST_MOD: begin
               // byte fold keeps the residue, then narrows it below 256
               if (mstep_ff == 6'd0) begin
                  rem_in = 32'(rem_ff[7:0]) + 32'(rem_ff[15:8]) * 32'(MOD_C1)
                         + 32'(rem_ff[23:16]) * 32'(MOD_C2)
                         + 32'(rem_ff[31:24]) * 32'(MOD_C3);
               end else begin
                  rem_in = 32'(rem_ff[7:0]) + 32'(rem_ff[13:8]) * 32'(MOD_C1);
               end
               mstep_in = mstep_ff + 6'd1;
               if (mstep_ff == 6'd3) begin
                  state_in = hbbc_pkg::ST_HRD;
               end
            end
            hbbc_pkg::ST_HRD: begin
               home_in  = MOD_TBL[32'(rem_ff[7:0]) * BW +: BW];
               found_in = 1'b0;
               cnt_in   = '0;
               raddr_in = '0;
               state_in = hbbc_pkg::ST_HCHK;
            end
            hbbc_pkg::ST_HCHK: begin
               // hit search, most recent match wins
               if (rd_data.bucket == home_ff && rd_data.dev == req_ff.device_id &&
                   rd_data.blk == req_ff.block_number &&
                   (!found_ff || rd_data.rank > brank_ff)) begin
                  found_in = 1'b1;
                  best_in  = scan_idx;
                  brank_in = rd_data.rank;
                  bent_in  = rd_data;
               end
               cnt_in   = cnt_nx;
               raddr_in = cnt_nx[AW-1:0];
               if (32'(cnt_nx) == NUM_BUFFERS) begin
                  cnt_in = '0;
                  state_in = hbbc_pkg::ST_HWR;
               end
            end
            hbbc_pkg::ST_HWR: begin
               if (found_ff) begin
                  if (32'(bent_ff.refs) >= hbbc_pkg::REFS_MAX) begin
                     rsp_in = '{5'(best_ff), 1'b1, 1'b0, hbbc_pkg::STATUS_OVERFLOW};
                  end else begin
                     wr_en         = 1'b1;
                     wr_addr       = best_ff;
                     wr_data       = bent_ff;
                     wr_data.refs  = bent_ff.refs + 6'd1;
                     wr_data.valid = 1'b1;
                     rsp_in = '{5'(best_ff), 1'b1, !bent_ff.valid,
                                hbbc_pkg::STATUS_OK};
                  end
                  state_in = hbbc_pkg::ST_DONE;
               end else begin
                  bkt_in   = (home_ff == '0) ? BW'(1) : '0;
                  cnt_in   = '0;
                  raddr_in = '0;
                  if (NUM_BUCKETS < 2 || (home_ff == '0 && NUM_BUCKETS == 1)) begin
                     state_in = hbbc_pkg::ST_VWR;
                  end else begin
                     state_in = hbbc_pkg::ST_VCHK;
                  end
               end
            end
            hbbc_pkg::ST_VCHK: begin
               // victim search within the current bucket, least recent free
               if (rd_data.bucket == bkt_ff && rd_data.refs == '0 &&
                   (!found_ff || rd_data.rank < brank_ff)) begin
                  found_in = 1'b1;
                  best_in  = scan_idx;
                  brank_in = rd_data.rank;
               end
               cnt_in   = cnt_nx;
               raddr_in = cnt_nx[AW-1:0];
               if (32'(cnt_nx) == NUM_BUFFERS) begin
                  cnt_in   = '0;
                  state_in = hbbc_pkg::ST_VBKT;
               end
            end
            hbbc_pkg::ST_VBKT: begin
               raddr_in = '0;
               if (found_ff) begin
                  old_in   = brank_ff;
                  state_in = hbbc_pkg::ST_RCHK;
               end else if ((32'(bkt_ff) + 1 == NUM_BUCKETS) ||
                            (32'(bkt_ff) + 2 == NUM_BUCKETS &&
                             32'(home_ff) + 1 == NUM_BUCKETS)) begin
                  state_in = hbbc_pkg::ST_VWR;
               end else begin
                  bkt_in   = (bkt_ff + BW'(1) == home_ff) ? bkt_ff + BW'(2)
                                                          : bkt_ff + BW'(1);
                  state_in = hbbc_pkg::ST_VCHK;
               end
            end
            hbbc_pkg::ST_VWR: begin
               // no free buffer
               rsp_in   = '{5'd0, 1'b0, 1'b0, hbbc_pkg::STATUS_NO_FREE};
               state_in = hbbc_pkg::ST_DONE;
            end
            hbbc_pkg::ST_RCHK: begin
               // recency update pass; victim retagged as most recent
               wr_en   = 1'b1;
               wr_addr = scan_idx;
               wr_data = rd_data;
               if (scan_idx == best_ff) begin
                  wr_data.dev    = req_ff.device_id;
                  wr_data.blk    = req_ff.block_number;
                  wr_data.refs   = 6'd1;
                  wr_data.valid  = 1'b1;
                  wr_data.bucket = home_ff;
                  wr_data.rank   = AW'(NUM_BUFFERS - 1);
               end else if (rd_data.rank > old_ff) begin
                  wr_data.rank = rd_data.rank - AW'(1);
               end
               cnt_in   = cnt_nx;
               raddr_in = cnt_nx[AW-1:0];
               if (32'(cnt_nx) == NUM_BUFFERS) begin
                  cnt_in = '0;
                  if (req_ff.kind == hbbc_pkg::KIND_GET) begin
                     rsp_in = '{5'(best_ff), 1'b0, 1'b1, hbbc_pkg::STATUS_OK};
                  end else begin
                     rsp_in = '{req_ff.buffer_index, 1'b0, 1'b0,
                                hbbc_pkg::STATUS_OK};
                  end
                  state_in = hbbc_pkg::ST_DONE;
               end
            end
            hbbc_pkg::ST_VRD: begin
               // read latency slot for single-slot kinds
               state_in = hbbc_pkg::ST_RRD;
            end
            hbbc_pkg::ST_RRD: begin
               rsp_in = '{req_ff.buffer_index, 1'b0, 1'b0, hbbc_pkg::STATUS_OK};
               state_in = hbbc_pkg::ST_DONE;
               if (req_ff.kind == hbbc_pkg::KIND_PIN) begin
                  if (32'(rd_data.refs) >= hbbc_pkg::REFS_MAX) begin
                     rsp_in.status = hbbc_pkg::STATUS_OVERFLOW;
                  end else begin
                     wr_en        = 1'b1;
                     wr_addr      = raddr_ff;
                     wr_data.refs = rd_data.refs + 6'd1;
                  end
               end else if (rd_data.refs == '0) begin
                  rsp_in.status = hbbc_pkg::STATUS_UNDERFLOW;
               end else begin
                  wr_en        = 1'b1;
                  wr_addr      = raddr_ff;
                  wr_data.refs = rd_data.refs - 6'd1;
                  if (req_ff.kind == hbbc_pkg::KIND_RELEASE && rd_data.refs == 6'd1) begin
                     // count reached zero: move to most recent
                     wr_en    = 1'b0;
                     best_in  = raddr_ff;
                     bent_in  = rd_data;
                     old_in   = rd_data.rank;
                     cnt_in   = '0;
                     raddr_in = '0;
                     state_in = hbbc_pkg::ST_RCHK;
                  end
               end
            end
            hbbc_pkg::ST_DONE: begin
               rv_in    = 1'b1;
               state_in = hbbc_pkg::ST_IDLE;
            end
            default: state_in = hbbc_pkg::ST_IDLE;
         endcase
         // release recency pass keeps its own tag, clears count
         if (state_ff == hbbc_pkg::ST_RCHK && req_ff.kind != hbbc_pkg::KIND_GET &&
             scan_idx == best_ff) begin
            wr_data      = rd_data;
            wr_data.refs = '0;
            wr_data.rank = AW'(NUM_BUFFERS - 1);
         end
      end
   end
endmodule
